// File: rtl/schc_pkg.sv
// Shared types and constants for the segment/circle hit test.
// No dependencies; used by the top level and the multiplier.
`default_nettype none

package schc_pkg;

  // Radius field is fixed by the word format
  localparam int RADIUS_W = 15;
  localparam int R2_W     = 2 * RADIUS_W;

  // Which point of the segment lies closest to the centre
  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_START    = 2'd1,
    REGION_END      = 2'd2
  } schc_region_t;

  // Stage loads for the split multiplier
  typedef struct packed {
    logic load_pp;   // partial products
    logic load_sum;  // recombined product
  } schc_mul_ctl_t;

endpackage

`default_nettype wire

// File: rtl/segment_circle_hit_test.sv
// Segment/circle hit test: seven stages, each with its own valid bit, lie between
// accepted word and result word. Throughput one word per cycle while the output
// is not stalled; a stalled output only holds back stages that are full, bubbles
// still fill up behind it. rst_n (synchronous, active low) empties every stage;
// payload is not cleared. Depends on schc_pkg and schc_mul.
`default_nettype none

module segment_circle_hit_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]       in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]       in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]       in_centre_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_centre_y,
  input  wire logic        [schc_pkg::RADIUS_W-1:0] in_radius,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_hit,
  output logic             [1:0]                   out_closest_region
);

  // D = E - S, W = C - S, F = C - E.
  // dot = W.D, len2 = D.D, cross = D x W.
  // dot < 0 or len2 = 0 : nearest is S, test |W|^2 <= r^2
  // dot > len2          : nearest is E, test |F|^2 <= r^2
  // otherwise           : interior, test cross^2 <= r^2 * len2

  localparam int DW   = COORD_WIDTH + 1;        // coordinate differences
  localparam int PW   = 2 * COORD_WIDTH + 2;    // signed products
  localparam int SW   = 2 * COORD_WIDTH + 3;    // signed sums of products
  localparam int CW   = 2 * COORD_WIDTH + 2;    // magnitudes: len2, |cross|, |W|^2
  localparam int R2W  = schc_pkg::R2_W;
  localparam int SQW  = (CW > R2W) ? CW : R2W;  // endpoint compare width
  localparam int XW   = 2 * CW;                 // cross^2
  localparam int LW   = CW + R2W;               // r^2 * len2
  localparam int CMPW = (XW > LW) ? XW : LW;

  // ---------------------------------------------------------------
  // Flow control: a stage may load when it is empty or the stage
  // after it is moving. Stage 7 is the output register.
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

  always_comb begin
    adv7 = !out_valid_r || !out_stall;
    adv6 = !v6_r || adv7;
    adv5 = !v5_r || adv6;
    adv4 = !v4_r || adv5;
    adv3 = !v3_r || adv4;
    adv2 = !v2_r || adv3;
    adv1 = !v1_r || adv2;
  end

  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) v4_r        <= v3_r;
      if (adv5) v5_r        <= v4_r;
      if (adv6) v6_r        <= v5_r;
      if (adv7) out_valid_r <= v6_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: differences
  // ---------------------------------------------------------------
  logic signed [DW-1:0] dx_r, dy_r, wx_r, wy_r, fx_r, fy_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt, wx_nxt, wy_nxt, fx_nxt, fy_nxt;
  logic [schc_pkg::RADIUS_W-1:0] rad1_r;

  always_comb begin
    dx_nxt = DW'(in_end_x)    - DW'(in_start_x);
    dy_nxt = DW'(in_end_y)    - DW'(in_start_y);
    wx_nxt = DW'(in_centre_x) - DW'(in_start_x);
    wy_nxt = DW'(in_centre_y) - DW'(in_start_y);
    fx_nxt = DW'(in_centre_x) - DW'(in_end_x);
    fy_nxt = DW'(in_centre_y) - DW'(in_end_y);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
      fx_r   <= fx_nxt;
      fy_r   <= fy_nxt;
      rad1_r <= in_radius;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: all the narrow products
  // ---------------------------------------------------------------
  logic signed [PW-1:0] dxdx_r, dydy_r, dxwx_r, dywy_r, dxwy_r, dywx_r;
  logic signed [PW-1:0] wxwx_r, wywy_r, fxfx_r, fyfy_r;
  logic        [R2W-1:0] r2_2_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      dxdx_r <= PW'(dx_r) * PW'(dx_r);
      dydy_r <= PW'(dy_r) * PW'(dy_r);
      dxwx_r <= PW'(dx_r) * PW'(wx_r);
      dywy_r <= PW'(dy_r) * PW'(wy_r);
      dxwy_r <= PW'(dx_r) * PW'(wy_r);
      dywx_r <= PW'(dy_r) * PW'(wx_r);
      wxwx_r <= PW'(wx_r) * PW'(wx_r);
      wywy_r <= PW'(wy_r) * PW'(wy_r);
      fxfx_r <= PW'(fx_r) * PW'(fx_r);
      fyfy_r <= PW'(fy_r) * PW'(fy_r);
      r2_2_r <= R2W'(rad1_r) * R2W'(rad1_r);
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: sums - len2, dot, cross and both endpoint distances
  // ---------------------------------------------------------------
  logic signed [SW-1:0] dot_r, cross_r;
  logic signed [SW-1:0] len2_s, ds_s, de_s;
  logic        [CW-1:0] len2_3_r, ds_r, de_r;
  logic        [R2W-1:0] r2_3_r;

  always_comb begin
    len2_s = SW'(dxdx_r) + SW'(dydy_r);
    ds_s   = SW'(wxwx_r) + SW'(wywy_r);
    de_s   = SW'(fxfx_r) + SW'(fyfy_r);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      dot_r    <= SW'(dxwx_r) + SW'(dywy_r);
      cross_r  <= SW'(dxwy_r) - SW'(dywx_r);
      len2_3_r <= len2_s[CW-1:0];   // non-negative, top bit always clear
      ds_r     <= ds_s[CW-1:0];
      de_r     <= de_s[CW-1:0];
      r2_3_r   <= r2_2_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: region choice, endpoint verdict, |cross|
  // ---------------------------------------------------------------
  schc_pkg::schc_region_t region_nxt, region4_r, region5_r, region6_r;
  logic                   ep_hit_nxt, ep_hit4_r, ep_hit5_r, ep_hit6_r;
  logic signed [SW-1:0]   cross_abs;
  logic        [CW-1:0]   cmag_r, len2_4_r;
  logic        [R2W-1:0]  r2_4_r;

  always_comb begin
    // degenerate segment goes to start, as does a projection before S;
    // projections exactly on either end count as interior
    if (len2_3_r == '0 || dot_r[SW-1]) begin
      region_nxt = schc_pkg::REGION_START;
    end else if (dot_r > $signed({1'b0, len2_3_r})) begin
      region_nxt = schc_pkg::REGION_END;
    end else begin
      region_nxt = schc_pkg::REGION_INTERIOR;
    end
    if (region_nxt == schc_pkg::REGION_END) begin
      ep_hit_nxt = SQW'(de_r) <= SQW'(r2_3_r);
    end else begin
      ep_hit_nxt = SQW'(ds_r) <= SQW'(r2_3_r);
    end
    cross_abs = cross_r[SW-1] ? -cross_r : cross_r;
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      region4_r <= region_nxt;
      ep_hit4_r <= ep_hit_nxt;
      cmag_r    <= cross_abs[CW-1:0];
      len2_4_r  <= len2_3_r;
      r2_4_r    <= r2_3_r;
    end
  end

  // ---------------------------------------------------------------
  // Stages 5 and 6: cross^2 and r^2 * len2 in split multipliers
  // ---------------------------------------------------------------
  schc_pkg::schc_mul_ctl_t mul_ctl;
  logic [XW-1:0] cross2;
  logic [LW-1:0] rlen2;

  assign mul_ctl = '{load_pp: adv5, load_sum: adv6};

  schc_mul #(
    .AW (CW),
    .BW (CW)
  ) u_mul_cross (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (cmag_r),
    .b   (cmag_r),
    .p   (cross2)
  );

  schc_mul #(
    .AW (CW),
    .BW (R2W)
  ) u_mul_rlen (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (len2_4_r),
    .b   (r2_4_r),
    .p   (rlen2)
  );

  // region and endpoint verdict ride alongside the multipliers
  always_ff @(posedge clk) begin
    if (adv5) begin
      region5_r <= region4_r;
      ep_hit5_r <= ep_hit4_r;
    end
    if (adv6) begin
      region6_r <= region5_r;
      ep_hit6_r <= ep_hit5_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 7: final compare into the output register
  // ---------------------------------------------------------------
  logic                   hit_nxt, hit_r;
  schc_pkg::schc_region_t region_out_r;

  always_comb begin
    if (region6_r == schc_pkg::REGION_INTERIOR) begin
      hit_nxt = CMPW'(cross2) <= CMPW'(rlen2);
    end else begin
      hit_nxt = ep_hit6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv7) begin
      hit_r        <= hit_nxt;
      region_out_r <= region6_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_closest_region = region_out_r;

endmodule

`default_nettype wire

// File: rtl/schc_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on schc_pkg for the stage-load struct.
`default_nettype none

module schc_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  wire logic                    clk,
  input  wire schc_pkg::schc_mul_ctl_t ctl,
  input  wire logic [AW-1:0]           a,
  input  wire logic [BW-1:0]           b,
  output logic      [AW+BW-1:0]        p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_r, ll_nxt;
  logic [AL+BH-1:0] lh_r, lh_nxt;
  logic [AH+BL-1:0] hl_r, hl_nxt;
  logic [AH+BH-1:0] hh_r, hh_nxt;
  logic [PW-1:0]    p_r, p_nxt;

  always_comb begin
    ll_nxt = (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
    lh_nxt = (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
    hl_nxt = (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
    hh_nxt = (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
  end

  // outer terms do not overlap, so they concatenate; the cross terms add in
  always_comb begin
    p_nxt = {hh_r, ll_r} + (PW'(lh_r) << BL) + (PW'(hl_r) << AL);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_pp) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
    end
    if (ctl.load_sum) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: rtl/schc_checker.sv
// Port-level checks for segment_circle_hit_test, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module schc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_hit,
  input wire logic [1:0] out_closest_region
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present straight after reset");

  // a free output register lets every stage move, so input is never held
  a_free_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_hit) && $stable(out_closest_region)))
    else $error("stalled result word changed");

endmodule

bind segment_circle_hit_test schc_checker u_schc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_hit            (out_hit),
  .out_closest_region (out_closest_region)
);

`default_nettype wire
